>>> src/cpsc_pkg.sv
`default_nettype none
package cpsc_pkg;

    // Input item kinds carried in s_tuser
    typedef enum logic [1:0] {
        OP_LOAD_ATOM = 2'd0,
        OP_LOAD_COEF = 2'd1,
        OP_QUERY     = 2'd2,
        OP_NONE      = 2'd3
    } opcode_t;

    localparam int COORD_W  = 20;
    localparam int TYPE_W   = 6;
    localparam int SLOT_W   = 6;
    localparam int LIMIT_W  = 7;
    localparam int COEF_W   = 32;
    localparam int QID_W    = 16;
    localparam int DIST_W   = 15;
    localparam int SQ_W     = 41;
    localparam int D2_W     = 42;
    localparam int RADIX_W  = 2 * DIST_W;
    localparam int CUTOFF_RESET = 4096;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [TYPE_W-1:0]         atype;
    } atom_t;

    typedef struct packed {
        logic [COEF_W-1:0] c12;
        logic [COEF_W-1:0] c6;
    } coef_t;

    // Handshake between the sequencer and the square root unit
    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_stat_t;

endpackage
`default_nettype wire

>>> src/cpsc_ram.sv
`default_nettype none
module cpsc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> src/cpsc_sqrt.sv
`default_nettype none
module cpsc_sqrt
    import cpsc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [RADIX_W-1:0] radicand,
    output sqrt_stat_t              stat,
    output logic      [DIST_W-1:0]  root
);

    localparam int REM_W = DIST_W + 2;

    logic [RADIX_W-1:0] v_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [DIST_W-1:0]  root_reg;
    logic [3:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [REM_W-1:0]   rem_shift;
    logic [REM_W-1:0]   trial;
    logic               take;

    // One result bit per cycle, restoring
    always_comb begin
        rem_shift = {rem_reg[REM_W-3:0], v_reg[RADIX_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        take      = rem_shift >= trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                v_reg    <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= 4'(DIST_W - 1);
            end else if (busy_reg) begin
                v_reg    <= {v_reg[RADIX_W-3:0], 2'b00};
                rem_reg  <= take ? rem_shift - trial : rem_shift;
                root_reg <= {root_reg[DIST_W-2:0], take};
                cnt_reg  <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule
`default_nettype wire

>>> src/cutoff_pair_search_with_coefficients_top.sv
`default_nettype none
// Channel   Dir  Signals                           Contents
// s_        in   tvalid tready tdata[167:0] tuser  load and query requests
// m_        out  tvalid tready tdata[103:0] tlast  one beat per hit
// cfg_      in   wr_en wr_data[14:0]               cutoff distance
//
// A load is taken in one handshake. A query is accepted in idle, then each slot
// below its limit passes read, multiply, compare and next; a hit waits in sqrt
// (one root bit a cycle), push if an earlier hit is pending, and final at the end.
// Hits are held one deep so the last can be flagged; pushes stall while the
// output register is full, and the input is held off until the query ends.
// Reset clears control only; tile and coefficient memories are undefined.
module cutoff_pair_search_with_coefficients_top
    import cpsc_pkg::*;
#(
    parameter int TILE_ATOMS = 64,
    parameter int NUM_TYPES  = 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // slot, slot_limit, atom_type, other_type, x, y, z, coef_six,
    // coef_twelve, query_id, zero pad
    input  wire logic [167:0] s_tdata,
    // opcode
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // hit_slot, hit_query_id, pair_distance, pair_c6, pair_c12, zero pad
    output logic      [103:0] m_tdata,
    // last_hit
    output logic              m_tlast,
    input  wire logic         cfg_wr_en,
    input  wire logic [14:0]  cfg_wr_data
);

    localparam int SW  = $clog2(TILE_ATOMS);
    localparam int CW  = $clog2(TILE_ATOMS + 1);
    localparam int CAW = $clog2(NUM_TYPES * NUM_TYPES);

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_MUL, ST_CMP, ST_SQRT, ST_PUSH, ST_NEXT, ST_FINAL
    } state_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [DIST_W-1:0] distance;
        logic [COEF_W-1:0] c6;
        logic [COEF_W-1:0] c12;
    } hit_t;

    // Unpack request fields
    opcode_t                   in_op;
    logic [SLOT_W-1:0]         in_slot;
    logic [LIMIT_W-1:0]        in_limit;
    logic [TYPE_W-1:0]         in_ta;
    logic [TYPE_W-1:0]         in_tb;
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [COORD_W-1:0] in_z;
    logic [COEF_W-1:0]         in_c6;
    logic [COEF_W-1:0]         in_c12;
    logic [QID_W-1:0]          in_qid;

    assign in_op    = opcode_t'(s_tuser);
    assign in_slot  = s_tdata[5:0];
    assign in_limit = s_tdata[12:6];
    assign in_ta    = s_tdata[18:13];
    assign in_tb    = s_tdata[24:19];
    assign in_x     = s_tdata[44:25];
    assign in_y     = s_tdata[64:45];
    assign in_z     = s_tdata[84:65];
    assign in_c6    = s_tdata[116:85];
    assign in_c12   = s_tdata[148:117];
    assign in_qid   = s_tdata[164:149];

    state_t                    state_reg;
    logic [DIST_W-1:0]         cutoff_reg;
    logic [RADIX_W-1:0]        c2_reg;
    logic [CW-1:0]             cnt_reg;
    logic [CW-1:0]             lim_reg;
    logic signed [COORD_W-1:0] qx_reg;
    logic signed [COORD_W-1:0] qy_reg;
    logic signed [COORD_W-1:0] qz_reg;
    logic [TYPE_W-1:0]         qt_reg;
    logic [QID_W-1:0]          qid_reg;
    logic [SQ_W-1:0]           sqx_reg;
    logic [SQ_W-1:0]           sqy_reg;
    logic [SQ_W-1:0]           sqz_reg;
    logic [TYPE_W-1:0]         at_reg;
    logic                      coef_ok_reg;
    hit_t                      pend_reg;
    logic                      pend_valid_reg;
    logic                      m_tvalid_reg;
    logic                      m_tlast_reg;
    hit_t                      m_hit_reg;
    logic [QID_W-1:0]          m_qid_reg;

    logic                      accept;
    logic                      out_free;
    logic                      push_out;
    atom_t                     atom_wdata;
    atom_t                     atom_rdata;
    logic                      atom_we;
    logic                      atom_re;
    logic                      coef_we;
    logic                      coef_re;
    logic [CAW-1:0]            coef_waddr;
    logic [CAW-1:0]            coef_raddr;
    coef_t                     coef_wdata;
    coef_t                     coef_rdata;
    logic [TYPE_W-1:0]         lo_w;
    logic [TYPE_W-1:0]         hi_w;
    logic [TYPE_W-1:0]         lo_r;
    logic [TYPE_W-1:0]         hi_r;
    logic [D2_W-1:0]           d2;
    logic                      is_hit;
    logic                      sqrt_start;
    sqrt_stat_t                sqrt_stat;
    logic [DIST_W-1:0]         sqrt_root;
    hit_t                      new_hit;
    logic [CW-1:0]             lim_sat;
    logic signed [COORD_W:0]   dx;
    logic signed [COORD_W:0]   dy;
    logic signed [COORD_W:0]   dz;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign push_out = out_free && (state_reg inside {ST_PUSH, ST_FINAL});

    // Memory requests, distance compare and hit fields
    always_comb begin
        atom_wdata = '{x: in_x, y: in_y, z: in_z, atype: in_ta};
        atom_we    = accept && (in_op == OP_LOAD_ATOM) && (32'(in_slot) < TILE_ATOMS);
        atom_re    = (state_reg == ST_READ);
        lo_w       = (in_ta < in_tb) ? in_ta : in_tb;
        hi_w       = (in_ta < in_tb) ? in_tb : in_ta;
        coef_waddr = CAW'(32'(lo_w) * NUM_TYPES + 32'(hi_w));
        coef_wdata = '{c12: in_c12, c6: in_c6};
        coef_we    = accept && (in_op == OP_LOAD_COEF) && (32'(in_ta) < NUM_TYPES)
                     && (32'(in_tb) < NUM_TYPES);
        lo_r       = (qt_reg < at_reg) ? qt_reg : at_reg;
        hi_r       = (qt_reg < at_reg) ? at_reg : qt_reg;
        coef_raddr = CAW'(32'(lo_r) * NUM_TYPES + 32'(hi_r));
        d2         = D2_W'(sqx_reg) + D2_W'(sqy_reg) + D2_W'(sqz_reg);
        is_hit     = d2 <= D2_W'(c2_reg);
        coef_re    = (state_reg == ST_CMP) && is_hit;
        sqrt_start = coef_re;
        lim_sat    = (32'(in_limit) > TILE_ATOMS) ? CW'(TILE_ATOMS) : CW'(in_limit);
        dx         = {qx_reg[COORD_W-1], qx_reg} - {atom_rdata.x[COORD_W-1], atom_rdata.x};
        dy         = {qy_reg[COORD_W-1], qy_reg} - {atom_rdata.y[COORD_W-1], atom_rdata.y};
        dz         = {qz_reg[COORD_W-1], qz_reg} - {atom_rdata.z[COORD_W-1], atom_rdata.z};
        new_hit.slot     = SLOT_W'(cnt_reg);
        new_hit.distance = sqrt_root;
        new_hit.c6       = coef_ok_reg ? coef_rdata.c6 : '0;
        new_hit.c12      = coef_ok_reg ? coef_rdata.c12 : '0;
    end

    cpsc_ram #(.WIDTH($bits(atom_t)), .DEPTH(TILE_ATOMS)) u_atom_ram (
        .aclk  (aclk),
        .we    (atom_we),
        .waddr (in_slot[SW-1:0]),
        .wdata (atom_wdata),
        .re    (atom_re),
        .raddr (cnt_reg[SW-1:0]),
        .rdata (atom_rdata)
    );

    cpsc_ram #(.WIDTH($bits(coef_t)), .DEPTH(NUM_TYPES * NUM_TYPES)) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .re    (coef_re),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    cpsc_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (d2[RADIX_W-1:0]),
        .stat     (sqrt_stat),
        .root     (sqrt_root)
    );

    // Sequencer: walk slots, hold one pending hit, push to output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cutoff_reg     <= DIST_W'(CUTOFF_RESET);
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cutoff_reg <= cfg_wr_data;
            end
            if (m_tready && !push_out) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && in_op == OP_QUERY) begin
                        qx_reg  <= in_x;
                        qy_reg  <= in_y;
                        qz_reg  <= in_z;
                        qt_reg  <= in_ta;
                        qid_reg <= in_qid;
                        lim_reg <= lim_sat;
                        cnt_reg <= '0;
                        if (lim_sat != '0) begin
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    sqx_reg   <= SQ_W'(dx * dx);
                    sqy_reg   <= SQ_W'(dy * dy);
                    sqz_reg   <= SQ_W'(dz * dz);
                    at_reg    <= atom_rdata.atype;
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    coef_ok_reg <= (32'(qt_reg) < NUM_TYPES) && (32'(at_reg) < NUM_TYPES);
                    state_reg   <= is_hit ? ST_SQRT : ST_NEXT;
                end
                ST_SQRT: begin
                    if (sqrt_stat.done) begin
                        if (pend_valid_reg) begin
                            state_reg <= ST_PUSH;
                        end else begin
                            pend_reg       <= new_hit;
                            pend_valid_reg <= 1'b1;
                            state_reg      <= ST_NEXT;
                        end
                    end
                end
                ST_PUSH: begin
                    if (out_free) begin
                        m_hit_reg    <= pend_reg;
                        m_qid_reg    <= qid_reg;
                        m_tlast_reg  <= 1'b0;
                        m_tvalid_reg <= 1'b1;
                        pend_reg     <= new_hit;
                        state_reg    <= ST_NEXT;
                    end
                end
                ST_NEXT: begin
                    if (cnt_reg + CW'(1) == lim_reg) begin
                        state_reg <= pend_valid_reg ? ST_FINAL : ST_IDLE;
                    end else begin
                        cnt_reg   <= cnt_reg + CW'(1);
                        state_reg <= ST_READ;
                    end
                end
                ST_FINAL: begin
                    if (out_free) begin
                        m_hit_reg      <= pend_reg;
                        m_qid_reg      <= qid_reg;
                        m_tlast_reg    <= 1'b1;
                        m_tvalid_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Cutoff squared, refreshed every cycle
    always_ff @(posedge aclk) begin
        c2_reg <= RADIX_W'(cutoff_reg) * RADIX_W'(cutoff_reg);
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {3'b000, m_hit_reg.c12, m_hit_reg.c6, m_hit_reg.distance,
                       m_qid_reg, m_hit_reg.slot};

    // No hit stays pending across requests
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pend_valid_reg)
        else $error("pending hit left while idle");

    // Slot walk stays below the limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (cnt_reg < lim_reg))
        else $error("slot counter past limit");

    // Root finishes only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_stat.done |-> (state_reg == ST_SQRT))
        else $error("square root result unexpected");

    // The final hit is presented, flagged last, once the output register is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINAL && out_free) |=> (m_tvalid && m_tlast))
        else $error("final hit not presented");

endmodule
`default_nettype wire

>>> verif/tb_cutoff_pair_search_with_coefficients_top.sv
`timescale 1ns / 1ps
module tb_cutoff_pair_search_with_coefficients_top;
    import cpsc_pkg::*;

    localparam int TILE  = 64;
    localparam int NTYPE = 64;

    typedef struct {
        opcode_t            op;
        logic [5:0]         slot;
        logic [6:0]         lim;
        logic [5:0]         ta;
        logic [5:0]         tb;
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] z;
        logic [31:0]        c6;
        logic [31:0]        c12;
        logic [15:0]        qid;
    } pair_req_t;

    typedef struct {
        logic [5:0]  slot;
        logic [15:0] qid;
        logic [14:0] distance;
        logic [31:0] c6;
        logic [31:0] c12;
        logic        last;
    } pair_hit_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [167:0] s_tdata = '0;
    logic [1:0]   s_tuser = OP_NONE;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic         m_tlast;
    logic         cfg_wr_en = 1'b0;
    logic [14:0]  cfg_wr_data = '0;

    cutoff_pair_search_with_coefficients_top u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // Request stream and hits still owed by the block
    pair_req_t req_queue[$];
    pair_hit_t hits_due[$];
    int        fail_count = 0;
    bit        idle_on = 1'b1;
    bit        hold_req = 1'b0;

    // Predictor state: tile, coefficient table, cutoff
    longint      tile_x[TILE], tile_y[TILE], tile_z[TILE];
    logic [5:0]  tile_type[TILE];
    logic [31:0] tbl_c6[NTYPE*NTYPE], tbl_c12[NTYPE*NTYPE];
    longint      cutoff_now = CUTOFF_RESET;

    // Generator shadow, used to keep queries off unwritten entries
    logic signed [19:0] gen_x[TILE], gen_y[TILE], gen_z[TILE];
    logic [5:0]         gen_type[TILE];
    bit                 coef_known[NTYPE*NTYPE];

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned root = 0;
        longint unsigned rem = v;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root;
    endfunction

    function automatic int pair_index(logic [5:0] a, logic [5:0] b);
        return (a < b) ? (int'(a) * NTYPE + int'(b)) : (int'(b) * NTYPE + int'(a));
    endfunction

    // Update the tile and table, or work out the hits of a query
    function automatic void predict_hits(pair_req_t r);
        longint    dx, dy, dz, d2, c2;
        int        lim, idx;
        pair_hit_t h;
        pair_hit_t found[$];
        case (r.op)
            OP_LOAD_ATOM: begin
                tile_x[r.slot] = longint'(r.x);
                tile_y[r.slot] = longint'(r.y);
                tile_z[r.slot] = longint'(r.z);
                tile_type[r.slot] = r.ta;
            end
            OP_LOAD_COEF: begin
                idx = pair_index(r.ta, r.tb);
                tbl_c6[idx] = r.c6;
                tbl_c12[idx] = r.c12;
            end
            OP_QUERY: begin
                lim = (r.lim > TILE) ? TILE : int'(r.lim);
                c2 = cutoff_now * cutoff_now;
                for (int s = 0; s < lim; s++) begin
                    dx = longint'(r.x) - tile_x[s];
                    dy = longint'(r.y) - tile_y[s];
                    dz = longint'(r.z) - tile_z[s];
                    d2 = dx * dx + dy * dy + dz * dz;
                    if (d2 <= c2) begin
                        idx = pair_index(r.ta, tile_type[s]);
                        h.slot = s[5:0];
                        h.qid = r.qid;
                        h.distance = 15'(floor_root(d2));
                        h.c6 = tbl_c6[idx];
                        h.c12 = tbl_c12[idx];
                        h.last = 1'b0;
                        found = {found, h};
                    end
                end
                if (found.size() > 0) found[found.size()-1].last = 1'b1;
                foreach (found[i]) hits_due = {hits_due, found[i]};
            end
            default: ;
        endcase
    endfunction

    // Drive requests; predict on each accepted one
    pair_req_t cur_req;
    int        gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) predict_hits(cur_req);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (req_queue.size() > 0 && !(idle_on && $urandom_range(0, 5) == 0)) begin
                    cur_req = req_queue.pop_front();
                    s_tdata <= {3'b0, cur_req.qid, cur_req.c12, cur_req.c6, cur_req.z,
                                cur_req.y, cur_req.x, cur_req.tb, cur_req.ta,
                                cur_req.lim, cur_req.slot};
                    s_tuser <= cur_req.op;
                    s_tvalid <= 1'b1;
                end else begin
                    if (req_queue.size() > 0) gap_left = $urandom_range(0, 5);
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver backpressure, plus one long hold-off on request
    int  stall_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                stall_left = 700;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 5);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare each hit with the oldest one owed
    pair_hit_t want_hit;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (hits_due.size() == 0) begin
                $error("hit_slot: expected none, actual %0d", m_tdata[5:0]);
                fail_count++;
            end else begin
                want_hit = hits_due.pop_front();
                check_field("hit_slot", want_hit.slot, m_tdata[5:0]);
                check_field("hit_query_id", want_hit.qid, m_tdata[21:6]);
                check_field("pair_distance", want_hit.distance, m_tdata[36:22]);
                check_field("pair_c6", want_hit.c6, m_tdata[68:37]);
                check_field("pair_c12", want_hit.c12, m_tdata[100:69]);
                check_field("last_hit", want_hit.last, m_tlast);
            end
        end
    end

    function automatic pair_req_t random_req();
        pair_req_t r;
        r.op = OP_NONE;
        r.slot = 6'($urandom);
        r.lim = 7'($urandom);
        r.ta = 6'($urandom);
        r.tb = 6'($urandom);
        r.x = 20'($urandom);
        r.y = 20'($urandom);
        r.z = 20'($urandom);
        r.c6 = $urandom;
        r.c12 = $urandom;
        r.qid = 16'($urandom);
        return r;
    endfunction

    function automatic logic signed [19:0] near_coord();
        if ($urandom_range(0, 29) == 0) return 20'($urandom);
        return 20'($signed($urandom_range(0, 12000)) - 6000);
    endfunction

    function automatic logic [5:0] pick_type();
        return ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(0, 3));
    endfunction

    task automatic add_atom(int slot, logic signed [19:0] x, logic signed [19:0] y,
                            logic signed [19:0] z, logic [5:0] t);
        pair_req_t r = random_req();
        r.op = OP_LOAD_ATOM;
        r.slot = slot[5:0];
        r.x = x;
        r.y = y;
        r.z = z;
        r.ta = t;
        gen_x[slot] = x;
        gen_y[slot] = y;
        gen_z[slot] = z;
        gen_type[slot] = t;
        req_queue = {req_queue, r};
    endtask

    task automatic add_coef(logic [5:0] a, logic [5:0] b, logic [31:0] c6, logic [31:0] c12);
        pair_req_t r = random_req();
        r.op = OP_LOAD_COEF;
        r.ta = a;
        r.tb = b;
        r.c6 = c6;
        r.c12 = c12;
        coef_known[pair_index(a, b)] = 1'b1;
        req_queue = {req_queue, r};
    endtask

    // Load any missing coefficient pair first, then issue the query
    task automatic add_query(int lim, logic signed [19:0] x, logic signed [19:0] y,
                             logic signed [19:0] z, logic [5:0] t, logic [15:0] qid);
        pair_req_t r = random_req();
        int        top;
        top = (lim > TILE) ? TILE : lim;
        for (int s = 0; s < top; s++) begin
            if (!coef_known[pair_index(t, gen_type[s])])
                add_coef(t, gen_type[s], $urandom, $urandom);
        end
        r.op = OP_QUERY;
        r.lim = lim[6:0];
        r.x = x;
        r.y = y;
        r.z = z;
        r.ta = t;
        r.qid = qid;
        req_queue = {req_queue, r};
    endtask

    // Mixed traffic over a fully written tile
    task automatic add_mixed(int n, bit exact_bias);
        pair_req_t r;
        int        pick, s;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                add_atom($urandom_range(0, 63), near_coord(), near_coord(), near_coord(),
                         pick_type());
            end else if (pick < 35) begin
                add_coef(6'($urandom), 6'($urandom), $urandom, $urandom);
            end else if (pick < 40) begin
                r = random_req();
                req_queue = {req_queue, r};
            end else if (exact_bias && $urandom_range(0, 1) == 0) begin
                s = $urandom_range(0, 63);
                add_query($urandom_range(0, 127), gen_x[s], gen_y[s], gen_z[s], pick_type(),
                          16'($urandom));
            end else begin
                add_query($urandom_range(0, 127), near_coord(), near_coord(), near_coord(),
                          pick_type(), 16'($urandom));
            end
        end
    endtask

    task automatic drain_and_write(logic [14:0] value);
        while (req_queue.size() != 0 || s_tvalid || hits_due.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cutoff_now = value;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: coordinate extremes, cutoff boundary, type order, no-op
        add_atom(0, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 6'd63);
        add_atom(1, 20'sh80000, 20'sh80000, 20'sh80000, 6'd0);
        add_atom(2, 20'sd0, 20'sd0, 20'sd0, 6'd0);
        add_atom(3, 20'sd4096, 20'sd0, 20'sd0, 6'd63);
        add_atom(4, 20'sd0, 20'sd4097, 20'sd0, 6'd5);
        add_coef(6'd0, 6'd0, 32'hFFFF_FFFF, 32'h0);
        add_coef(6'd63, 6'd0, 32'h1234_5678, 32'hFFFF_FFFF);
        add_coef(6'd63, 6'd63, 32'h0, 32'hFFFF_FFFF);
        add_coef(6'd5, 6'd0, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        req_queue = {req_queue, random_req()};
        add_query(0, 20'sd0, 20'sd0, 20'sd0, 6'd0, 16'h0000);
        add_query(5, 20'sd0, 20'sd0, 20'sd0, 6'd0, 16'hFFFF);
        add_query(5, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 6'd0, 16'h1111);
        add_query(2, 20'sh80000, 20'sh80000, 20'sh80000, 6'd63, 16'h2222);
        add_query(1, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 6'd63, 16'h3333);
        add_query(5, 20'sd2048, 20'sd0, 20'sd0, 6'd5, 16'h4444);

        // Widest cutoff: fill the tile, then long queries
        drain_and_write(15'd32767);
        for (int s = 0; s < TILE; s++)
            add_atom(s, near_coord(), near_coord(), near_coord(), pick_type());
        add_query(127, 20'sd0, 20'sd0, 20'sd0, 6'd1, 16'h5555);
        add_query(64, 20'sh7FFFF, 20'sd0, 20'sh80000, 6'd2, 16'h6666);
        add_mixed(6, 1'b0);

        // Zero cutoff: only exact matches hit
        drain_and_write(15'd0);
        add_mixed(14, 1'b1);

        // Typical cutoff, with a long receiver hold-off
        drain_and_write(15'($urandom_range(2000, 8000)));
        hold_req = 1'b1;
        add_mixed(30, 1'b0);

        // Last part: random cutoff, no idling
        drain_and_write(15'($urandom_range(0, 32767)));
        idle_on = 1'b0;
        add_mixed(30, 1'b0);

        while (req_queue.size() != 0 || s_tvalid || hits_due.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
